### hw/rtl/lsrw_pkg.sv
// ----------------------------------------------------------------------------
// lsrw_pkg
// Shared types and codes for the latest-slot read/write lock table.
// ----------------------------------------------------------------------------
`default_nettype none

package lsrw_pkg;

    typedef struct packed {
        logic [1:0] cmd;
        logic [5:0] slot_index;
    } req_t;

    typedef struct packed {
        logic       granted;
        logic [5:0] granted_slot;
        logic [1:0] status;
    } rsp_t;

    localparam logic [1:0] CMD_WR_ACQ = 2'd0;
    localparam logic [1:0] CMD_WR_REL = 2'd1;
    localparam logic [1:0] CMD_RD_ACQ = 2'd2;
    localparam logic [1:0] CMD_RD_REL = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BUSY  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [7:0] LOCK_FREE   = 8'h00;
    localparam logic [7:0] LOCK_WRITE  = 8'hFF;
    localparam logic [7:0] READERS_MAX = 8'd254;

    localparam logic [6:0] SLOTS_RESET = 7'd4;

endpackage

`default_nettype wire

### hw/rtl/latest_slot_rw_lock_table.sv
// ----------------------------------------------------------------------------
// latest_slot_rw_lock_table
// Lock table for one writer and many readers over a set of buffer slots.
//
//   port        dir  width   role
//   req_*       in   8       lock request transaction (cmd, slot_index)
//   rsp_*       out  9       lock response transaction (granted, slot, status)
//   cfg_*       in   7       slots_in_use register write
//
// Releases and read acquires read the lock word from the slot memory, then
// update it. A write acquire scans slots one at a time from slot 0,
// limited by the single read port of the slot memory, and answers busy
// without a scan when no slot is in use. Reset clears per-slot valid flags,
// so the table is usable straight after reset without clearing the slot
// memory. A held response stalls the next completion, not the next request
// acceptance.
// ----------------------------------------------------------------------------
`default_nettype none

module latest_slot_rw_lock_table #(
    parameter int MAX_SLOTS = 64
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_ready,
    input  wire lsrw_pkg::req_t req,
    output logic                rsp_valid,
    input  wire                 rsp_ready,
    output lsrw_pkg::rsp_t      rsp,
    input  wire                 cfg_we,
    input  wire  [6:0]          cfg_wdata
);

    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int LW = (IW + 1 > 7) ? IW + 1 : 7;
    localparam logic [LW-1:0] MAX_L = LW'(MAX_SLOTS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;
    localparam logic [1:0] S_HOLD  = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [1:0]           cmd_reg, cmd_next;
    logic [IW-1:0]        addr_reg, addr_next;
    logic [IW-1:0]        cnt_reg, cnt_next;
    lsrw_pkg::rsp_t       res_reg, res_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    lsrw_pkg::rsp_t       rsp_reg, rsp_next;
    logic [6:0]           slots_reg;
    logic                 latest_valid_reg, latest_valid_next;
    logic [5:0]           latest_slot_reg, latest_slot_next;

    logic [7:0]           mem [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] vld_reg;
    logic [7:0]           rd_data_reg;
    logic                 rd_vld_reg;

    logic [IW-1:0]        rd_addr;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic [7:0]           wr_data;
    logic [7:0]           word;
    logic [LW-1:0]        lim;
    logic [LW-1:0]        slots_ext;
    logic [LW-1:0]        idx_ext;
    logic [LW-1:0]        lat_ext;
    logic [LW-1:0]        cnt_inc;
    logic                 finish;
    lsrw_pkg::rsp_t       res;
    logic                 out_free;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign slots_ext = LW'(slots_reg);
    assign lim       = (slots_ext > MAX_L) ? MAX_L : slots_ext;
    assign idx_ext   = LW'(req.slot_index);
    assign lat_ext   = LW'(latest_slot_reg);
    assign cnt_inc   = LW'(cnt_reg) + LW'(1);
    assign word      = rd_vld_reg ? rd_data_reg : lsrw_pkg::LOCK_FREE;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        addr_next         = addr_reg;
        cnt_next          = cnt_reg;
        res_next          = res_reg;
        latest_valid_next = latest_valid_reg;
        latest_slot_next  = latest_slot_reg;
        rd_addr           = '0;
        wr_en             = 1'b0;
        wr_addr           = addr_reg;
        wr_data           = lsrw_pkg::LOCK_FREE;
        finish            = 1'b0;
        res               = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next = req.cmd;
                    case (req.cmd)
                        lsrw_pkg::CMD_WR_ACQ:
                        begin
                            if (lim == '0)
                            begin
                                res_next        = '0;
                                res_next.status = lsrw_pkg::ST_BUSY;
                                state_next      = S_HOLD;
                            end
                            else
                            begin
                                rd_addr    = '0;
                                cnt_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        lsrw_pkg::CMD_RD_ACQ:
                        begin
                            if (!latest_valid_reg || lat_ext >= MAX_L)
                            begin
                                res_next        = '0;
                                res_next.status = lsrw_pkg::ST_EMPTY;
                                state_next      = S_HOLD;
                            end
                            else
                            begin
                                rd_addr    = lat_ext[IW-1:0];
                                addr_next  = lat_ext[IW-1:0];
                                state_next = S_CHECK;
                            end
                        end
                        default:
                        begin
                            if (idx_ext >= MAX_L)
                            begin
                                res_next   = '0;
                                state_next = S_HOLD;
                            end
                            else
                            begin
                                rd_addr    = idx_ext[IW-1:0];
                                addr_next  = idx_ext[IW-1:0];
                                state_next = S_CHECK;
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (word == lsrw_pkg::LOCK_FREE)
                begin
                    wr_en            = 1'b1;
                    wr_addr          = cnt_reg;
                    wr_data          = lsrw_pkg::LOCK_WRITE;
                    finish           = 1'b1;
                    res.granted      = 1'b1;
                    res.granted_slot = LW'(cnt_reg) >> 0 == '0 ? 6'd0 : cnt_inc[5:0] - 6'd1;
                    res.status       = lsrw_pkg::ST_OK;
                end
                else if (cnt_inc >= lim)
                begin
                    finish     = 1'b1;
                    res.status = lsrw_pkg::ST_BUSY;
                end
                else
                begin
                    cnt_next = cnt_inc[IW-1:0];
                    rd_addr  = cnt_inc[IW-1:0];
                end
            end
            S_CHECK:
            begin
                finish = 1'b1;
                case (cmd_reg)
                    lsrw_pkg::CMD_WR_REL:
                    begin
                        if (word == lsrw_pkg::LOCK_WRITE)
                        begin
                            wr_en             = 1'b1;
                            wr_data           = lsrw_pkg::LOCK_FREE;
                            latest_valid_next = 1'b1;
                            latest_slot_next  = LW'(addr_reg) >> 0 == '0 ? 6'd0
                                                : lat_ext[5:0] & 6'd0 | 6'(LW'(addr_reg));
                            res.granted       = 1'b1;
                        end
                    end
                    lsrw_pkg::CMD_RD_ACQ:
                    begin
                        if (word == lsrw_pkg::LOCK_WRITE || word >= lsrw_pkg::READERS_MAX)
                        begin
                            res.status = lsrw_pkg::ST_BUSY;
                        end
                        else
                        begin
                            wr_en            = 1'b1;
                            wr_data          = word + 8'd1;
                            res.granted      = 1'b1;
                            res.granted_slot = latest_slot_reg;
                        end
                    end
                    lsrw_pkg::CMD_RD_REL:
                    begin
                        if (word != lsrw_pkg::LOCK_FREE && word != lsrw_pkg::LOCK_WRITE)
                        begin
                            wr_en       = 1'b1;
                            wr_data     = word - 8'd1;
                            res.granted = 1'b1;
                        end
                    end
                    default:
                    begin
                        res = '0;
                    end
                endcase
            end
            S_HOLD:
            begin
                res = res_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            res_next   = res;
            state_next = out_free ? S_IDLE : S_HOLD;
        end
        else if (state_reg == S_HOLD && out_free)
        begin
            state_next = S_IDLE;
        end

        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        if ((finish || state_reg == S_HOLD) && out_free)
        begin
            rsp_next       = res;
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        cmd_reg     <= cmd_next;
        addr_reg    <= addr_next;
        cnt_reg     <= cnt_next;
        res_reg     <= res_next;
        rsp_reg     <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            rsp_valid_reg    <= 1'b0;
            slots_reg        <= lsrw_pkg::SLOTS_RESET;
            latest_valid_reg <= 1'b0;
            latest_slot_reg  <= '0;
            vld_reg          <= '0;
            rd_vld_reg       <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rsp_valid_reg    <= rsp_valid_next;
            latest_valid_reg <= latest_valid_next;
            latest_slot_reg  <= latest_slot_next;
            rd_vld_reg       <= vld_reg[rd_addr];
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (cfg_we)
            begin
                slots_reg <= cfg_wdata;
            end
        end
    end

    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.granted |-> rsp.status == lsrw_pkg::ST_OK)
        else $error("granted response with non-ok status");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> LW'(cnt_reg) < lim)
        else $error("scan index beyond slot limit");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while previous one in flight");

    a_latest_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(latest_valid_reg))
        else $error("published flag dropped");

endmodule

`default_nettype wire
